[src/csv_integer_field_parser_defines.svh]
// Assertion helpers for the parser.
`ifndef CSV_INTEGER_FIELD_PARSER_DEFINES_SVH
`define CSV_INTEGER_FIELD_PARSER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CSVIP_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("csv parser check failed");

// The consequent must hold in the cycle after the antecedent.
`define CSVIP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("csv parser check failed");

`endif

[src/csvip_pkg.sv]
package csvip_pkg;

  localparam int unsigned ByteBits  = 8;
  localparam int unsigned FieldBits = 32;

  localparam logic [ByteBits-1:0] ChQuote   = 8'h22;
  localparam logic [ByteBits-1:0] ChNewline = 8'h0A;
  localparam logic [ByteBits-1:0] ChNul     = 8'h00;
  localparam logic [ByteBits-1:0] ChSpace   = 8'h20;
  localparam logic [ByteBits-1:0] ChTab     = 8'h09;
  localparam logic [ByteBits-1:0] ChCr      = 8'h0D;
  localparam logic [ByteBits-1:0] ChPlus    = 8'h2B;
  localparam logic [ByteBits-1:0] ChMinus   = 8'h2D;
  localparam logic [ByteBits-1:0] ChZero    = 8'h30;
  localparam logic [ByteBits-1:0] ChNine    = 8'h39;
  localparam logic [ByteBits-1:0] DelimReset = 8'h2C;

  // Progress of the atoi-style conversion of the current field.
  typedef enum logic [1:0] {
    PH_SKIP_WS = 2'd0,
    PH_SIGN    = 2'd1,
    PH_DIGITS  = 2'd2,
    PH_STOPPED = 2'd3
  } conv_phase_e;

endpackage

[src/csvip_byte_if.sv]
interface csvip_byte_if;
  logic                               valid;
  logic                               ready;
  logic [csvip_pkg::ByteBits-1:0]     text_byte;
  logic                               end_of_stream;

  modport source (output valid, output text_byte, output end_of_stream, input ready);
  modport sink   (input valid, input text_byte, input end_of_stream, output ready);
endinterface

[src/csvip_field_if.sv]
interface csvip_field_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [csvip_pkg::FieldBits-1:0] field_value;
  logic                                  last_in_line;
  logic                                  saturated;

  modport source (output valid, output field_value, output last_in_line, output saturated,
                  input ready);
  modport sink   (input valid, input field_value, input last_in_line, input saturated,
                  output ready);
endinterface

[src/csv_integer_field_parser.sv]
// Each byte is parsed as it leaves the input register; a field ends in one beat of
// the result register. Throughput: one byte beat per cycle while not stalled.
// The input register takes a new beat while a result waits, and stalls only when
// both the input register and the result register are full.
// Reset (rst_ni low, asynchronous) clears all parse state, empties both registers
// and sets the delimiter back to a comma.
`include "csv_integer_field_parser_defines.svh"

module csv_integer_field_parser #(
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [csvip_pkg::ByteBits-1:0]   cfg_wdata_i,
  csvip_byte_if.sink                       byte_i,
  csvip_field_if.source                    field_o
);

  // Magnitude bound: the negative limit, one past the largest positive value.
  localparam logic [VALUE_BITS-1:0] MagLimit = {1'b1, {(VALUE_BITS-1){1'b0}}};
  localparam logic [VALUE_BITS-1:0] MaxPos   = {1'b0, {(VALUE_BITS-1){1'b1}}};

  // Delimiter: the user must write it only while the parser is idle; not enforced.
  logic [csvip_pkg::ByteBits-1:0] delim_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delim_q <= csvip_pkg::DelimReset;
    end else if (cfg_we_i) begin
      delim_q <= cfg_wdata_i;
    end
  end

  // ---------------------------------------------------------------------------
  // Input register. It advances whenever the result register can take a beat,
  // whether or not the byte in it produces one.
  // ---------------------------------------------------------------------------
  logic                           s1_valid_q, s1_valid_d;
  logic [csvip_pkg::ByteBits-1:0] s1_byte_q;
  logic                           s1_eos_q;
  logic                           s1_adv, s2_fire, in_fire;

  assign s1_adv      = !field_o.valid || field_o.ready;
  assign s2_fire     = s1_valid_q && s1_adv;
  assign byte_i.ready = !s1_valid_q || s1_adv;
  assign in_fire     = byte_i.valid && byte_i.ready;

  always_comb begin
    if (in_fire) begin
      s1_valid_d = 1'b1;
    end else if (s2_fire) begin
      s1_valid_d = 1'b0;
    end else begin
      s1_valid_d = s1_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_byte_q <= byte_i.text_byte;
      s1_eos_q  <= byte_i.end_of_stream;
    end
  end

  // ---------------------------------------------------------------------------
  // Parse state.
  // ---------------------------------------------------------------------------
  logic                   in_quotes_q, in_quotes_d;
  logic                   quote_pend_q, quote_pend_d;
  logic                   nonempty_q, nonempty_d;
  csvip_pkg::conv_phase_e phase_q, phase_d;
  logic                   neg_q, neg_d;
  logic [VALUE_BITS-1:0]  mag_q, mag_d;
  logic                   ovf_q, ovf_d;
  logic                   halted_q, halted_d;
  logic                   has_bytes_q, has_bytes_d;

  // Character classes of the byte being parsed.
  logic is_ws, is_sign, is_digit;

  assign is_ws    = (s1_byte_q == csvip_pkg::ChSpace) ||
                    ((s1_byte_q >= csvip_pkg::ChTab) && (s1_byte_q <= csvip_pkg::ChCr));
  assign is_sign  = (s1_byte_q == csvip_pkg::ChPlus) || (s1_byte_q == csvip_pkg::ChMinus);
  assign is_digit = (s1_byte_q >= csvip_pkg::ChZero) && (s1_byte_q <= csvip_pkg::ChNine);

  // Multiply-by-ten accumulate as two shifted adds. The product stays below
  // sixteen times the limit, so four extra bits hold it.
  logic [VALUE_BITS+3:0] acc_sum;
  logic [3:0]            digit_val;

  assign digit_val = 4'(s1_byte_q - csvip_pkg::ChZero);
  assign acc_sum   = ({4'b0, mag_q} << 3) + ({4'b0, mag_q} << 1) +
                     (VALUE_BITS+4)'(digit_val);

  // Field state after one more character is added to the field.
  csvip_pkg::conv_phase_e push_phase;
  logic                   push_neg;
  logic [VALUE_BITS-1:0]  push_mag;
  logic                   push_ovf;

  always_comb begin
    push_phase = phase_q;
    push_neg   = neg_q;
    unique case (phase_q) inside
      csvip_pkg::PH_SKIP_WS: begin
        if (is_sign) begin
          push_neg   = (s1_byte_q == csvip_pkg::ChMinus);
          push_phase = csvip_pkg::PH_SIGN;
        end else if (!is_ws) begin
          push_phase = is_digit ? csvip_pkg::PH_DIGITS : csvip_pkg::PH_STOPPED;
        end
      end
      csvip_pkg::PH_SIGN, csvip_pkg::PH_DIGITS: begin
        push_phase = is_digit ? csvip_pkg::PH_DIGITS : csvip_pkg::PH_STOPPED;
      end
      default: begin
        push_phase = phase_q;
      end
    endcase
  end

  // A digit extends the value in every phase but the stopped one; once the
  // value has clamped it stays at the limit.
  always_comb begin
    push_mag = mag_q;
    push_ovf = ovf_q;
    if (is_digit && (phase_q != csvip_pkg::PH_STOPPED) && !ovf_q) begin
      if (acc_sum > (VALUE_BITS+4)'(MagLimit)) begin
        push_ovf = 1'b1;
        push_mag = MagLimit;
      end else begin
        push_mag = acc_sum[VALUE_BITS-1:0];
      end
    end
  end

  // Byte decode: quoting, delimiters, line ends and the halt on NUL.
  logic emit, emit_last;

  always_comb begin
    logic inq;
    logic skip;
    logic push;
    logic clr_field;
    logic clr_line;
    inq       = in_quotes_q;
    skip      = 1'b0;
    push      = 1'b0;
    clr_field = 1'b0;
    clr_line  = 1'b0;
    emit      = 1'b0;
    emit_last = 1'b0;

    in_quotes_d  = in_quotes_q;
    quote_pend_d = quote_pend_q;
    halted_d     = halted_q;
    has_bytes_d  = has_bytes_q;

    if (s2_fire) begin
      if (s1_eos_q) begin
        // End of stream flushes a line only if it holds any byte.
        emit      = has_bytes_q;
        emit_last = 1'b1;
        clr_line  = 1'b1;
      end else if (s1_byte_q == csvip_pkg::ChNewline) begin
        // A newline ends the line even inside quotes, and an empty line
        // still gives one zero field.
        emit      = 1'b1;
        emit_last = 1'b1;
        clr_line  = 1'b1;
      end else begin
        has_bytes_d = 1'b1;
        if (!halted_q) begin
          if (quote_pend_q) begin
            quote_pend_d = 1'b0;
            if (s1_byte_q == csvip_pkg::ChQuote) begin
              // A doubled quote is one literal quote character.
              push = 1'b1;
              skip = 1'b1;
            end else begin
              inq = 1'b0;
            end
          end
          if (!skip) begin
            if (s1_byte_q == csvip_pkg::ChNul) begin
              halted_d = 1'b1;
            end else if (!inq && !nonempty_q && (s1_byte_q == csvip_pkg::ChQuote)) begin
              inq = 1'b1;
            end else if (inq && (s1_byte_q == csvip_pkg::ChQuote)) begin
              quote_pend_d = 1'b1;
            end else if (!inq && (s1_byte_q == delim_q)) begin
              emit      = 1'b1;
              clr_field = 1'b1;
            end else begin
              push = 1'b1;
            end
          end
          in_quotes_d = inq;
        end
      end
    end

    nonempty_d = nonempty_q;
    phase_d    = phase_q;
    neg_d      = neg_q;
    mag_d      = mag_q;
    ovf_d      = ovf_q;
    if (push) begin
      nonempty_d = 1'b1;
      phase_d    = push_phase;
      neg_d      = push_neg;
      mag_d      = push_mag;
      ovf_d      = push_ovf;
    end
    if (clr_field || clr_line) begin
      nonempty_d = 1'b0;
      phase_d    = csvip_pkg::PH_SKIP_WS;
      neg_d      = 1'b0;
      mag_d      = '0;
      ovf_d      = 1'b0;
    end
    if (clr_line) begin
      in_quotes_d  = 1'b0;
      quote_pend_d = 1'b0;
      halted_d     = 1'b0;
      has_bytes_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_quotes_q  <= 1'b0;
      quote_pend_q <= 1'b0;
      nonempty_q   <= 1'b0;
      phase_q      <= csvip_pkg::PH_SKIP_WS;
      neg_q        <= 1'b0;
      mag_q        <= '0;
      ovf_q        <= 1'b0;
      halted_q     <= 1'b0;
      has_bytes_q  <= 1'b0;
    end else begin
      in_quotes_q  <= in_quotes_d;
      quote_pend_q <= quote_pend_d;
      nonempty_q   <= nonempty_d;
      phase_q      <= phase_d;
      neg_q        <= neg_d;
      mag_q        <= mag_d;
      ovf_q        <= ovf_d;
      halted_q     <= halted_d;
      has_bytes_q  <= has_bytes_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Field value. A negative field that clamped reads as the negative limit; a
  // positive one clamps to the largest positive value, which also catches a
  // magnitude that reached the limit without clamping.
  // ---------------------------------------------------------------------------
  logic [VALUE_BITS-1:0] val;
  logic                  val_sat;

  always_comb begin
    if (neg_q) begin
      val_sat = ovf_q;
      val     = ovf_q ? MagLimit : (~mag_q + 1'b1);
    end else if (ovf_q || (mag_q > MaxPos)) begin
      val_sat = 1'b1;
      val     = MaxPos;
    end else begin
      val_sat = 1'b0;
      val     = mag_q;
    end
  end

  // Result register.
  logic out_valid_q, out_valid_d;

  always_comb begin
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (field_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      field_o.field_value  <= csvip_pkg::FieldBits'(val);
      field_o.last_in_line <= emit_last;
      field_o.saturated    <= val_sat;
    end
  end

  assign field_o.valid = out_valid_q;

  // ---------------------------------------------------------------------------
  // Checks.
  // ---------------------------------------------------------------------------
  `CSVIP_ASSERT_NOW(a_pend_in_quotes, quote_pend_q, in_quotes_q)
  `CSVIP_ASSERT_NOW(a_halt_has_bytes, halted_q, has_bytes_q)
  `CSVIP_ASSERT_NOW(a_ovf_at_limit, ovf_q, mag_q == MagLimit)
  `CSVIP_ASSERT_NEXT(a_eos_clears_line, s2_fire && s1_eos_q, !has_bytes_q && !in_quotes_q)
  `CSVIP_ASSERT_NOW(a_full_stalls_input, s1_valid_q && field_o.valid && !field_o.ready,
                    !byte_i.ready)

endmodule

[test/csv_integer_field_parser_tb.sv]
module csv_integer_field_parser_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // The block is built with its default value width, so the saturation limits
  // below are the 32-bit signed limits.
  localparam int unsigned ValueBits  = 32;
  localparam logic [63:0] FieldLimit = 64'd1 << (ValueBits - 1);
  localparam logic [63:0] ValueMask  = (FieldLimit - 64'd1) * 64'd2 + 64'd1;

  // Cycles without a beat on either channel before the run is declared hung.
  // The longest legal quiet stretch is the deliberate output stall below.
  localparam int unsigned QuietLimit  = 2000;
  localparam int unsigned StallCycles = 300;
  // Cycles allowed after the last expected field for bytes that cause no field.
  localparam int unsigned SettleCycles = 4;

  // One expected or observed field beat.
  typedef struct packed {
    logic signed [csvip_pkg::FieldBits-1:0] value;
    logic                                   last;
    logic                                   sat;
  } field_beat_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  logic                           cfg_we_i    = 1'b0;
  logic [csvip_pkg::ByteBits-1:0] cfg_wdata_i = '0;

  csvip_byte_if  byte_if ();
  csvip_field_if field_if ();

  csv_integer_field_parser #(
    .VALUE_BITS(ValueBits)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .byte_i     (byte_if),
    .field_o    (field_if)
  );

  always #5 clk_i = ~clk_i;

  // Shared run state: idling switch for both sides, output stall request,
  // failure count, and the number of byte beats accepted so far.
  bit          gaps_on = 1'b1;
  int          stall_left = 0;
  int unsigned fail_count = 0;
  int unsigned beats_sent = 0;

  // Fields the parser model has produced and the block has not yet returned.
  field_beat_t pending_fields[$];

  // ---------------------------------------------------------------------------
  // Parser model. It mirrors the block's line and field state and is advanced
  // once for every byte beat the block accepts.
  // ---------------------------------------------------------------------------
  logic [csvip_pkg::ByteBits-1:0] delim_shadow;
  bit                             in_quotes, quote_pending, field_nonempty;
  csvip_pkg::conv_phase_e         phase;
  bit                             is_negative, overflowed, line_halted, line_has_bytes;
  logic [63:0]                    magnitude;

  function automatic void clear_field();
    field_nonempty = 1'b0;
    phase          = csvip_pkg::PH_SKIP_WS;
    is_negative    = 1'b0;
    magnitude      = '0;
    overflowed     = 1'b0;
  endfunction

  function automatic void clear_line();
    clear_field();
    in_quotes      = 1'b0;
    quote_pending  = 1'b0;
    line_halted    = 1'b0;
    line_has_bytes = 1'b0;
  endfunction

  // Feeds one field character into the atoi-style conversion.
  function automatic void push_field_char(logic [csvip_pkg::ByteBits-1:0] c);
    bit          digit;
    logic [63:0] d;
    digit = (c >= csvip_pkg::ChZero) && (c <= csvip_pkg::ChNine);
    field_nonempty = 1'b1;
    if (phase == csvip_pkg::PH_SKIP_WS) begin
      // Leading whitespace is space or any of tab, LF, VT, FF and CR.
      if (c == csvip_pkg::ChSpace || (c >= csvip_pkg::ChTab && c <= csvip_pkg::ChCr)) return;
      if (c == csvip_pkg::ChPlus || c == csvip_pkg::ChMinus) begin
        is_negative = (c == csvip_pkg::ChMinus);
        phase = csvip_pkg::PH_SIGN;
        return;
      end
      phase = digit ? csvip_pkg::PH_DIGITS : csvip_pkg::PH_STOPPED;
    end else if (phase == csvip_pkg::PH_SIGN || phase == csvip_pkg::PH_DIGITS) begin
      phase = digit ? csvip_pkg::PH_DIGITS : csvip_pkg::PH_STOPPED;
    end
    if (phase == csvip_pkg::PH_DIGITS && !overflowed) begin
      d = {56'd0, c - csvip_pkg::ChZero};
      // Once the magnitude would pass the negative limit it is pinned there.
      if (magnitude > (FieldLimit - d) / 64'd10) begin
        overflowed = 1'b1;
        magnitude  = FieldLimit;
      end else begin
        magnitude = magnitude * 64'd10 + d;
      end
    end
  endfunction

  // Turns the current field into its saturated value and starts a new field.
  function automatic field_beat_t close_field(bit last);
    field_beat_t beat;
    logic [63:0] v;
    bit          sat;
    sat = overflowed;
    if (is_negative) begin
      v = sat ? FieldLimit : (64'd0 - magnitude);
    end else if (sat || magnitude > FieldLimit - 64'd1) begin
      // A positive magnitude of exactly the negative limit still clamps.
      sat = 1'b1;
      v   = FieldLimit - 64'd1;
    end else begin
      v = magnitude;
    end
    v = v & ValueMask;
    beat.value = v[csvip_pkg::FieldBits-1:0];
    beat.last  = last;
    beat.sat   = sat;
    clear_field();
    return beat;
  endfunction

  // Advances the model by one byte beat; returns 1 when a field completes.
  function automatic bit parse_byte(input logic [csvip_pkg::ByteBits-1:0] b,
                                    input logic eos, output field_beat_t beat);
    bit produced;
    produced = 1'b0;
    beat     = '0;
    if (eos) begin
      // End of stream flushes only a line that holds at least one byte.
      if (line_has_bytes) begin
        beat     = close_field(1'b1);
        produced = 1'b1;
      end
      clear_line();
      return produced;
    end
    // A newline ends the line even inside quotes or after a NUL, and an empty
    // line still gives a zero field.
    if (b == csvip_pkg::ChNewline) begin
      beat = close_field(1'b1);
      clear_line();
      return 1'b1;
    end
    line_has_bytes = 1'b1;
    if (line_halted) return 1'b0;
    if (quote_pending) begin
      quote_pending = 1'b0;
      if (b == csvip_pkg::ChQuote) begin
        // Doubled quote inside quotes: one literal quote character.
        push_field_char(b);
        return 1'b0;
      end
      in_quotes = 1'b0;
    end
    if (b == csvip_pkg::ChNul) begin
      line_halted = 1'b1;
      return 1'b0;
    end
    // The quote rules are checked first, so a quote delimiter only splits
    // outside quotes in a field that already holds characters.
    if (!in_quotes && !field_nonempty && b == csvip_pkg::ChQuote) begin
      in_quotes = 1'b1;
    end else if (in_quotes && b == csvip_pkg::ChQuote) begin
      quote_pending = 1'b1;
    end else if (!in_quotes && b == delim_shadow) begin
      beat = close_field(1'b0);
      return 1'b1;
    end else begin
      push_field_char(b);
    end
    return 1'b0;
  endfunction

  // ---------------------------------------------------------------------------
  // Scoreboard. Byte beats are fed to the model first, then any field beat of
  // the same edge is compared with the oldest prediction.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : field_check
    field_beat_t predicted;
    field_beat_t want;
    if (rst_ni) begin
      if (byte_if.valid && byte_if.ready) begin
        if (parse_byte(byte_if.text_byte, byte_if.end_of_stream, predicted)) begin
          pending_fields = {pending_fields, predicted};
        end
      end
      if (field_if.valid && field_if.ready) begin
        if (pending_fields.size() == 0) begin
          $error("unexpected field beat: field_value %0d", field_if.field_value);
          fail_count++;
        end else begin
          want = pending_fields.pop_front();
          if (field_if.field_value !== want.value) begin
            $error("field_value mismatch: expected %0d, actual %0d",
                   want.value, field_if.field_value);
            fail_count++;
          end
          if (field_if.last_in_line !== want.last) begin
            $error("last_in_line mismatch: expected %0b, actual %0b",
                   want.last, field_if.last_in_line);
            fail_count++;
          end
          if (field_if.saturated !== want.sat) begin
            $error("saturated mismatch: expected %0b, actual %0b",
                   want.sat, field_if.saturated);
            fail_count++;
          end
        end
      end
    end
  end

  // Receiver: random back-pressure, plus a long hold-off when a test asks for
  // one. The hold-off is counted here so the sender keeps offering bytes and
  // the block fills up and stalls its input.
  initial begin
    field_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (stall_left > 0) begin
        field_if.ready <= 1'b0;
        stall_left--;
      end else if (gaps_on && $urandom_range(99) < 31) begin
        field_if.ready <= 1'b0;
      end else begin
        field_if.ready <= 1'b1;
      end
    end
  end

  // Watchdog: ends the run when neither channel moves for too long.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QuietLimit) begin
      @(posedge clk_i);
      if ((byte_if.valid && byte_if.ready) || (field_if.valid && field_if.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("TEST FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Sender side.
  // ---------------------------------------------------------------------------

  // Offers one byte beat and returns at the edge where it is taken. Valid is
  // left high so the next beat can follow without a bubble; it only drops for
  // a random gap or when the stream pauses.
  task automatic send_beat(input logic [csvip_pkg::ByteBits-1:0] b, input logic eos);
    while (gaps_on && $urandom_range(99) < 31) begin
      byte_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    byte_if.valid         <= 1'b1;
    byte_if.text_byte     <= b;
    byte_if.end_of_stream <= eos;
    @(posedge clk_i);
    while (!byte_if.ready) @(posedge clk_i);
    beats_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_beat(s[i], 1'b0);
  endtask

  // Sends a field in quotes, doubling every quote inside it.
  task automatic send_quoted(input string s);
    send_beat(csvip_pkg::ChQuote, 1'b0);
    for (int i = 0; i < s.len(); i++) begin
      if (s[i] == csvip_pkg::ChQuote) send_beat(csvip_pkg::ChQuote, 1'b0);
      send_beat(s[i], 1'b0);
    end
    send_beat(csvip_pkg::ChQuote, 1'b0);
  endtask

  // Stops offering and waits until every predicted field is back and any
  // bytes still inside the block that cause no field have drained.
  task automatic wait_drained();
    byte_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_fields.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_delimiter(input logic [csvip_pkg::ByteBits-1:0] d);
    wait_drained();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= d;
    @(posedge clk_i);
    cfg_we_i     <= 1'b0;
    delim_shadow  = d;
  endtask

  // Builds the text of one integer field: optional whitespace, optional sign,
  // digits from small values up to well past the 32-bit range, optional tail.
  function automatic string make_field_text();
    string           s;
    logic [7:0]      ws_set[5];
    longint unsigned near_limit;
    int unsigned     hi, lo;
    ws_set = '{csvip_pkg::ChSpace, csvip_pkg::ChTab, 8'h0B, 8'h0C, csvip_pkg::ChCr};
    s = "";
    if ($urandom_range(3) == 0) begin
      repeat ($urandom_range(1, 3)) s = {s, $sformatf("%c", ws_set[$urandom_range(4)])};
    end
    case ($urandom_range(3))
      0: s = {s, "+"};
      1: s = {s, "-"};
      default: ;
    endcase
    hi = $urandom;
    lo = $urandom;
    case ($urandom_range(7))
      0: ;
      1, 2: s = {s, $sformatf("%0d", $urandom_range(999))};
      3: s = {s, $sformatf("%0d", hi)};
      4: begin
        // Straddles both saturation limits.
        near_limit = 64'd2147483640 + $urandom_range(15);
        s = {s, $sformatf("%0d", near_limit)};
      end
      5: s = {s, $sformatf("%0d%0d", hi, lo)};
      default: s = {s, $sformatf("000%0d", $urandom_range(99))};
    endcase
    if ($urandom_range(4) == 0) s = {s, $sformatf("%c", $urandom_range(33, 126))};
    return s;
  endfunction

  // A well-formed line of up to four fields, mostly ended by a newline,
  // sometimes by end of stream or cut short by a NUL.
  task automatic send_random_line();
    int unsigned n_fields;
    n_fields = $urandom_range(4);
    for (int f = 0; f < n_fields; f++) begin
      if ($urandom_range(3) == 0) send_quoted(make_field_text());
      else send_text(make_field_text());
      if ($urandom_range(19) == 0) send_beat(8'($urandom_range(255)), 1'b0);
      if (f + 1 < n_fields) send_beat(delim_shadow, 1'b0);
    end
    case ($urandom_range(19))
      0: send_beat(8'($urandom_range(255)), 1'b1);
      1: begin
        send_beat(csvip_pkg::ChNul, 1'b0);
        repeat ($urandom_range(4)) send_beat(8'($urandom_range(255)), 1'b0);
        send_beat(csvip_pkg::ChNewline, 1'b0);
      end
      default: send_beat(csvip_pkg::ChNewline, 1'b0);
    endcase
  endtask

  // A line that breaks off mid-field: an open quote or stray bytes.
  task automatic send_broken_line();
    send_text(make_field_text());
    if ($urandom_range(1)) send_beat(csvip_pkg::ChQuote, 1'b0);
    repeat ($urandom_range(1, 4)) send_beat(8'($urandom_range(255)), 1'b0);
    if ($urandom_range(2) == 0) send_beat(csvip_pkg::ChQuote, 1'b0);
    send_beat(csvip_pkg::ChNewline, $urandom_range(3) == 0);
  endtask

  task automatic run_random(input int unsigned n);
    int unsigned start;
    int unsigned pick;
    start = beats_sent;
    while (beats_sent - start < n) begin
      pick = $urandom_range(99);
      if (pick < 75) begin
        send_random_line();
      end else if (pick < 90) begin
        repeat ($urandom_range(1, 12)) begin
          send_beat(8'($urandom_range(255)), $urandom_range(15) == 0);
        end
      end else begin
        send_broken_line();
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------

  // Short hand-picked lines under the reset comma delimiter.
  task automatic test_directed_cases();
    // Empty line still gives a zero field.
    send_text("\n");
    // Whitespace and plus sign, then a quote that is not at field start
    // and so is a plain character that stops conversion.
    send_text("\t+7\"9,");
    // Quoted field with a doubled quote; text after the closing quote
    // joins the field but conversion has already stopped.
    send_text("\"-5\"\"1\"2\n");
    // Bare sign gives zero, and a NUL hides the rest of the line.
    send_text("-");
    send_beat(csvip_pkg::ChNul, 1'b0);
    send_text(",9\n");
    // High byte, then end of stream flushes the unterminated line.
    send_beat(8'hFF, 1'b0);
    send_beat(8'hFF, 1'b1);
    // End of stream on an empty line gives nothing.
    send_beat(8'h00, 1'b1);
  endtask

  task automatic test_comma_random();
    run_random(550);
  endtask

  // Walks the delimiter through its extremes and the awkward values: NUL,
  // which never delimits, and quote, which loses to the quoting rules.
  task automatic test_delimiter_sweep();
    logic [csvip_pkg::ByteBits-1:0] delims[7];
    delims = '{8'h00, 8'hFF, csvip_pkg::ChQuote, 8'h3B, csvip_pkg::ChTab,
               csvip_pkg::ChMinus, 8'h00};
    delims[6] = 8'($urandom_range(255));
    foreach (delims[i]) begin
      write_delimiter(delims[i]);
      run_random(100);
    end
  endtask

  // A long stretch with no idling on either side, back at the comma.
  task automatic test_back_to_back();
    write_delimiter(csvip_pkg::DelimReset);
    gaps_on = 1'b0;
    run_random(200);
    wait_drained();
    gaps_on = 1'b1;
  endtask

  // The receiver holds off while the sender keeps offering, so both internal
  // registers fill and the block must stall its input without losing a beat.
  task automatic test_output_stall();
    write_delimiter(8'h7C);
    stall_left = StallCycles;
    run_random(150);
  endtask

  initial begin
    byte_if.valid         <= 1'b0;
    byte_if.text_byte     <= '0;
    byte_if.end_of_stream <= 1'b0;
    delim_shadow = csvip_pkg::DelimReset;
    clear_line();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_cases();
    test_comma_random();
    test_delimiter_sweep();
    test_back_to_back();
    test_output_stall();

    wait_drained();
    repeat (8) @(posedge clk_i);
    if (fail_count == 0 && pending_fields.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
